// ===== sv/blc_pkg.sv =====
// Shared types and constants of the block cache LRU lookup.
package blc_pkg;

   localparam int ENTRIES     = 20;
   localparam int OFFSET_BITS = 40;
   localparam int AGE_BITS    = 32;
   localparam int SLOT_BITS   = 6;
   localparam int LEN_BITS    = OFFSET_BITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   // Search record that walks down the row of cells, one cell per cycle.
   typedef struct packed {
      logic                   valid;
      logic                   hit;
      logic [SLOT_BITS-1:0]   idx;
      logic [AGE_BITS-1:0]    best_age;
      logic [OFFSET_BITS-1:0] tag;
   } search_type;

   // Write-back broadcast to every cell after a search completes; it also carries the age clear on a counter wrap.
   typedef struct packed {
      logic                   en;
      logic                   clear_age;
      logic [SLOT_BITS-1:0]   slot;
      logic [OFFSET_BITS-1:0] tag;
      logic [AGE_BITS-1:0]    age;
   } update_type;

endpackage

// ===== sv/blc_if.sv =====
// Request and response channel interfaces of the block cache LRU lookup.
interface blc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            is_compressed;
   logic [blc_pkg::OFFSET_BITS-1:0] block_offset;
   logic [blc_pkg::OFFSET_BITS-1:0] next_offset;

   modport source (output valid, output is_compressed, output block_offset,
                   output next_offset, input ready);
   modport sink (input valid, input is_compressed, input block_offset,
                 input next_offset, output ready);
endinterface

interface blc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                bypass;
   logic                                hit;
   logic [blc_pkg::SLOT_BITS-1:0]       slot;
   logic signed [blc_pkg::LEN_BITS-1:0] comp_length;

   modport source (output valid, output bypass, output hit, output slot,
                   output comp_length, input ready);
   modport sink (input valid, input bypass, input hit, input slot,
                 input comp_length, output ready);
endinterface

// ===== sv/block_cache_lru_lookup.sv =====
// Top level of the block cache LRU lookup: request control, age counter and the row of entries.
// An uncompressed transaction is answered in the cycle after it is accepted and leaves the
// cache untouched. A compressed transaction advances the age counter (a wrap to zero clears
// every entry's age), then a search record walks the row of ENTRIES cells, one cell per cycle,
// picking up the first matching tag or else the lowest-indexed entry with the smallest age.
// The entry found is rewritten with the tag and the current age, and the response is loaded
// into the output register once that register is free; only then is the next transaction
// accepted. Tags reset to zero without valid bits, so offset zero hits entry zero after
// reset. One transaction is worked on at a time, and a response waiting in the output
// register holds off the next transaction until it is taken.
module block_cache_lru_lookup (
   input logic  clock,
   input logic  reset,
   blc_req_if.sink   req,
   blc_rsp_if.source rsp
);

   blc_pkg::state_type state_ff;
   blc_pkg::state_type state_in;

   logic [blc_pkg::AGE_BITS-1:0]         counter_ff;
   logic [blc_pkg::AGE_BITS-1:0]         counter_in;
   logic [blc_pkg::AGE_BITS-1:0]         counter_inc;
   logic signed [blc_pkg::LEN_BITS-1:0]  len_ff;
   logic signed [blc_pkg::LEN_BITS-1:0]  len_in;
   logic                                 pend_hit_ff;
   logic                                 pend_hit_in;
   logic [blc_pkg::SLOT_BITS-1:0]        pend_slot_ff;
   logic [blc_pkg::SLOT_BITS-1:0]        pend_slot_in;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic                                 rsp_bypass_ff;
   logic                                 rsp_bypass_in;
   logic                                 rsp_hit_ff;
   logic                                 rsp_hit_in;
   logic [blc_pkg::SLOT_BITS-1:0]        rsp_slot_ff;
   logic [blc_pkg::SLOT_BITS-1:0]        rsp_slot_in;
   logic signed [blc_pkg::LEN_BITS-1:0]  rsp_len_ff;
   logic signed [blc_pkg::LEN_BITS-1:0]  rsp_len_in;

   logic                                 req_ready_c;
   logic                                 scan_done;
   logic                                 rsp_load;
   logic                                 accept;
   logic                                 accept_comp;
   logic                                 accept_bypass;

   blc_pkg::search_type                  chain [blc_pkg::ENTRIES+1];
   blc_pkg::update_type                  update;

   assign accept        = req.valid && req_ready_c;
   assign accept_comp   = accept && req.is_compressed;
   assign accept_bypass = accept && !req.is_compressed;
   assign counter_inc   = counter_ff + 1'b1;

   always_comb begin
      req_ready_c = 1'b0;
      scan_done   = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         blc_pkg::ST_IDLE: begin
            req_ready_c = !rsp_valid_ff || rsp.ready;
         end
         blc_pkg::ST_SCAN: begin
            scan_done = chain[blc_pkg::ENTRIES].valid;
         end
         blc_pkg::ST_RESP: begin
            rsp_load = !rsp_valid_ff || rsp.ready;
         end
         default: begin
            req_ready_c = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         blc_pkg::ST_IDLE: begin
            if (accept_comp) begin
               state_in = blc_pkg::ST_SCAN;
            end
         end
         blc_pkg::ST_SCAN: begin
            if (chain[blc_pkg::ENTRIES].valid) begin
               state_in = blc_pkg::ST_RESP;
            end
         end
         blc_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = blc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = blc_pkg::ST_IDLE;
         end
      endcase
   end

   assign req.ready = req_ready_c;

   always_comb begin
      chain[0].valid    = accept_comp;
      chain[0].hit      = 1'b0;
      chain[0].idx      = '0;
      chain[0].best_age = '1;
      chain[0].tag      = req.block_offset;
   end

   always_comb begin
      update.en        = scan_done;
      update.clear_age = accept_comp && (counter_inc == '0);
      update.slot      = chain[blc_pkg::ENTRIES].idx;
      update.tag       = chain[blc_pkg::ENTRIES].tag;
      update.age       = counter_ff;
   end

   for (genvar i = 0; i < blc_pkg::ENTRIES; i++) begin : g_cell
      blc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (blc_pkg::SLOT_BITS'(i)),
         .search_i   (chain[i]),
         .update_i   (update),
         .search_o   (chain[i+1])
      );
   end

   always_comb begin
      counter_in   = accept_comp ? counter_inc : counter_ff;
      len_in       = accept_comp
                     ? ($signed({1'b0, req.next_offset}) - $signed({1'b0, req.block_offset}))
                     : len_ff;
      pend_hit_in  = scan_done ? chain[blc_pkg::ENTRIES].hit : pend_hit_ff;
      pend_slot_in = scan_done ? chain[blc_pkg::ENTRIES].idx : pend_slot_ff;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_bypass_in = rsp_bypass_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_len_in    = rsp_len_ff;
      if (accept_bypass) begin
         rsp_valid_in  = 1'b1;
         rsp_bypass_in = 1'b1;
         rsp_hit_in    = 1'b0;
         rsp_slot_in   = '0;
         rsp_len_in    = '0;
      end else if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_bypass_in = 1'b0;
         rsp_hit_in    = pend_hit_ff;
         rsp_slot_in   = pend_slot_ff;
         rsp_len_in    = len_ff;
      end else if (rsp.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blc_pkg::ST_IDLE;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff        <= len_in;
      pend_hit_ff   <= pend_hit_in;
      pend_slot_ff  <= pend_slot_in;
      rsp_bypass_ff <= rsp_bypass_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.bypass      = rsp_bypass_ff;
   assign rsp.hit         = rsp_hit_ff;
   assign rsp.slot        = rsp_slot_ff;
   assign rsp.comp_length = rsp_len_ff;

endmodule

// ===== sv/blc_cell.sv =====
// One cache entry: holds a tag and an age and advances the search record by one step.
module blc_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [blc_pkg::SLOT_BITS-1:0]   cell_index,
   input  blc_pkg::search_type             search_i,
   input  blc_pkg::update_type             update_i,
   output blc_pkg::search_type             search_o
);

   logic [blc_pkg::OFFSET_BITS-1:0] tag_ff;
   logic [blc_pkg::OFFSET_BITS-1:0] tag_in;
   logic [blc_pkg::AGE_BITS-1:0]    age_ff;
   logic [blc_pkg::AGE_BITS-1:0]    age_in;
   logic [blc_pkg::AGE_BITS-1:0]    age_seen;
   blc_pkg::search_type             search_ff;
   blc_pkg::search_type             search_in;

   // An age that is being cleared in this cycle already counts as zero for the search.
   assign age_seen = update_i.clear_age ? '0 : age_ff;

   always_comb begin
      search_in = search_i;
      if (!search_i.hit) begin
         if (tag_ff == search_i.tag) begin
            search_in.hit = 1'b1;
            search_in.idx = cell_index;
         end else if (age_seen < search_i.best_age) begin
            search_in.best_age = age_seen;
            search_in.idx      = cell_index;
         end
      end
   end

   always_comb begin
      tag_in = tag_ff;
      age_in = age_ff;
      if (update_i.clear_age) begin
         age_in = '0;
      end
      if (update_i.en && (update_i.slot == cell_index)) begin
         tag_in = update_i.tag;
         age_in = update_i.age;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff          <= '0;
         age_ff          <= '0;
         search_ff.valid <= 1'b0;
      end else begin
         tag_ff          <= tag_in;
         age_ff          <= age_in;
         search_ff.valid <= search_in.valid;
      end
      search_ff.hit      <= search_in.hit;
      search_ff.idx      <= search_in.idx;
      search_ff.best_age <= search_in.best_age;
      search_ff.tag      <= search_in.tag;
   end

   assign search_o = search_ff;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the block cache LRU lookup: directed and random lookups.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE   = 26;

   typedef struct packed {
      logic                                bypass;
      logic                                hit;
      logic [blc_pkg::SLOT_BITS-1:0]       slot;
      logic signed [blc_pkg::LEN_BITS-1:0] comp_length;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   blc_req_if req_ch ();
   blc_rsp_if rsp_ch ();

   block_cache_lru_lookup dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   logic [blc_pkg::OFFSET_BITS-1:0] cached_tag [blc_pkg::ENTRIES];
   logic [blc_pkg::AGE_BITS-1:0]    cached_age [blc_pkg::ENTRIES];
   logic [blc_pkg::AGE_BITS-1:0]    age_clock;
   lookup_result_type               pending_lookups [$];
   logic [blc_pkg::OFFSET_BITS-1:0] tag_pool [POOL_SIZE];

   int  cycles;
   int  errors;
   int  sent_count;
   int  hit_count;
   int  miss_count;
   int  bypass_count;
   int  rsp_hold_request;
   bit  no_idle;

   localparam logic [blc_pkg::OFFSET_BITS-1:0] OFF_MAX = '1;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb NOT OK");
      $finish;
   end

   function automatic logic [blc_pkg::OFFSET_BITS-1:0] rand_offset();
      return blc_pkg::OFFSET_BITS'({$urandom(), $urandom()});
   endfunction

   function automatic lookup_result_type predict_lookup(
         logic compressed,
         logic [blc_pkg::OFFSET_BITS-1:0] blk,
         logic [blc_pkg::OFFSET_BITS-1:0] nxt);
      lookup_result_type            r;
      logic [blc_pkg::AGE_BITS-1:0] best;
      int                           victim;
      int                           i;
      r = '0;
      if (!compressed) begin
         r.bypass = 1'b1;
         return r;
      end
      age_clock = age_clock + 1'b1;
      if (age_clock == '0) begin
         for (i = 0; i < blc_pkg::ENTRIES; i++) cached_age[i] = '0;
      end
      r.comp_length = {1'b0, nxt} - {1'b0, blk};
      for (i = 0; i < blc_pkg::ENTRIES; i++) begin
         if (cached_tag[i] == blk) begin
            cached_age[i] = age_clock;
            r.hit = 1'b1;
            r.slot = blc_pkg::SLOT_BITS'(i);
            return r;
         end
      end
      best = cached_age[0];
      victim = 0;
      for (i = 1; i < blc_pkg::ENTRIES; i++) begin
         if (cached_age[i] < best) begin
            best = cached_age[i];
            victim = i;
         end
      end
      cached_tag[victim] = blk;
      cached_age[victim] = age_clock;
      r.slot = blc_pkg::SLOT_BITS'(victim);
      return r;
   endfunction

   task automatic send_lookup(input logic compressed,
                              input logic [blc_pkg::OFFSET_BITS-1:0] blk,
                              input logic [blc_pkg::OFFSET_BITS-1:0] nxt);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.is_compressed <= compressed;
      req_ch.block_offset  <= blk;
      req_ch.next_offset   <= nxt;
      do @(posedge clock); while (!req_ch.ready);
      pending_lookups.push_back(predict_lookup(compressed, blk, nxt));
      sent_count++;
   endtask

   task automatic wait_all_answered();
      req_ch.valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   // Response side: random stalls, a long hold-off when one is requested, and the field check.
   initial begin
      int                stall;
      lookup_result_type want;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (rsp_hold_request > 0) begin
            stall = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_lookups.size() == 0) begin
            $error("unexpected response: bypass=%0b hit=%0b slot=%0d comp_length=%0d",
                   rsp_ch.bypass, rsp_ch.hit, rsp_ch.slot, rsp_ch.comp_length);
            errors++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_ch.bypass !== want.bypass) begin
               $error("bypass: expected %0b, actual %0b", want.bypass, rsp_ch.bypass);
               errors++;
            end
            if (rsp_ch.hit !== want.hit) begin
               $error("hit: expected %0b, actual %0b", want.hit, rsp_ch.hit);
               errors++;
            end
            if (rsp_ch.slot !== want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_ch.slot);
               errors++;
            end
            if (rsp_ch.comp_length !== want.comp_length) begin
               $error("comp_length: expected %0d, actual %0d",
                      want.comp_length, rsp_ch.comp_length);
               errors++;
            end
            if (want.bypass) bypass_count++;
            else if (want.hit) hit_count++;
            else miss_count++;
         end
      end
   end

   // Without valid bits every tag starts at zero, so offset zero hits entry zero.
   task automatic test_reset_state();
      send_lookup(1'b1, '0, 40'h100);
      send_lookup(1'b1, 40'h1234, 40'h1000);
      send_lookup(1'b1, 40'h5678, 40'h5678);
   endtask

   task automatic test_field_extremes();
      send_lookup(1'b0, OFF_MAX, OFF_MAX);
      send_lookup(1'b0, '0, '0);
      send_lookup(1'b1, OFF_MAX, '0);
      send_lookup(1'b1, '0, OFF_MAX);
      send_lookup(1'b1, OFF_MAX, OFF_MAX);
      send_lookup(1'b0, rand_offset(), rand_offset());
   endtask

   task automatic test_replacement_order();
      logic [blc_pkg::OFFSET_BITS-1:0] first_tag;
      int                              i;
      first_tag = rand_offset();
      send_lookup(1'b1, first_tag, rand_offset());
      for (i = 0; i < 13; i++) send_lookup(1'b1, rand_offset(), rand_offset());
      send_lookup(1'b1, first_tag, rand_offset());
      send_lookup(1'b1, rand_offset(), rand_offset());
   endtask

   task automatic send_random_lookup();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         send_lookup(1'b0, rand_offset(), rand_offset());
      else if (pick < 30)
         send_lookup(1'b1, rand_offset(), rand_offset());
      else
         send_lookup(1'b1, tag_pool[$urandom_range(0, POOL_SIZE - 1)], rand_offset());
   endtask

   task automatic test_stall_fill();
      int i;
      no_idle = 1'b1;
      rsp_hold_request = 300;
      for (i = 0; i < 12; i++) send_random_lookup();
      no_idle = 1'b0;
   endtask

   task automatic test_drain_pause();
      int i;
      int round;
      for (round = 0; round < 2; round++) begin
         for (i = 0; i < 8; i++) send_random_lookup();
         wait_all_answered();
      end
   endtask

   task automatic test_random_mix();
      int i;
      for (i = 0; i < 330; i++) begin
         no_idle = (i >= 150 && i < 190);
         send_random_lookup();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int i;
      errors = 0;
      sent_count = 0;
      hit_count = 0;
      miss_count = 0;
      bypass_count = 0;
      rsp_hold_request = 0;
      no_idle = 1'b0;
      age_clock = '0;
      for (i = 0; i < blc_pkg::ENTRIES; i++) begin
         cached_tag[i] = '0;
         cached_age[i] = '0;
      end
      for (i = 0; i < POOL_SIZE; i++) tag_pool[i] = rand_offset();
      tag_pool[0] = '0;
      tag_pool[1] = OFF_MAX;
      req_ch.valid         <= 1'b0;
      req_ch.is_compressed <= 1'b0;
      req_ch.block_offset  <= '0;
      req_ch.next_offset   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_field_extremes();
      test_replacement_order();
      test_stall_fill();
      test_drain_pause();
      test_random_mix();

      wait_all_answered();
      repeat (3 * blc_pkg::ENTRIES) @(posedge clock);
      if (pending_lookups.size() != 0) begin
         $error("%0d expected responses never arrived", pending_lookups.size());
         errors++;
      end
      $display("Sent %0d lookups: %0d hits, %0d misses, %0d bypasses checked.",
               sent_count, hit_count, miss_count, bypass_count);
      $display("Covered reset tags, offset extremes, LRU refill, output stall and drain.");
      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
